[hw/rtl/indexed_list_insert_remove_core_macros.svh]
// ----------------------------------------------------------------------------
// indexed list core assertion macros
// shared property wrappers for the list core checks
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_CORE_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_CORE_MACROS_SVH

// checked only while out of reset
`define ILIR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define ILIR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hw/rtl/ilir_pkg.sv]
// ----------------------------------------------------------------------------
// ilir_pkg
// command and status codes and the beat types of the indexed list core
// ----------------------------------------------------------------------------
`default_nettype none

package ilir_pkg;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    localparam int POS_W = 16;
    localparam int VAL_W = 32;
    localparam int LEN_W = 5;

    typedef struct packed {
        cmd_t                     cmd;
        logic signed [POS_W-1:0]  position;
        logic signed [VAL_W-1:0]  value;
    } op_t;

    typedef struct packed {
        status_t                  status;
        logic signed [VAL_W-1:0]  read_value;
        logic [LEN_W-1:0]         length;
    } res_t;

endpackage

`default_nettype wire

[hw/rtl/indexed_list_insert_remove_core.sv]
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_core: ordered list with insert/remove by position
// path: an accepted input beat goes through the input register, then the result
//       register, before its result beat shows on m_axis
// throughput: one beat per cycle while m_axis_tready stays high; every cell
//             shifts in the same cycle
// reset: aresetn low clears the element count and the valid flags of both beat registers
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_insert_remove_core_macros.svh"

module indexed_list_insert_remove_core #(
    parameter int MAX_ELEMENTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] cmd, [17:2] position, [49:18] value, [55:50] zero
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [33:2] read_value, [38:34] length, [39] zero
    output logic [39:0] m_axis_tdata
);
    import ilir_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ELEMENTS);

    logic in_valid_reg;
    op_t  in_reg;
    logic out_valid_reg;
    res_t out_reg;
    res_t res;
    logic advance;

    // item moves to the result register when that register is free or drains
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_reg.cmd      <= cmd_t'(s_axis_tdata[1:0]);
            in_reg.position <= s_axis_tdata[17:2];
            in_reg.value    <= s_axis_tdata[49:18];
        end
    end

    ilir_list #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_list (
        .aclk   (aclk),
        .aresetn(aresetn),
        .en     (advance),
        .op     (in_reg),
        .res    (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.length, out_reg.read_value, out_reg.status};

    `ILIR_ASSERT(a_full_len,
        (out_valid_reg && out_reg.status == ST_FULL) |-> (out_reg.length == MAX_LEN),
        "refused beat without full length")
    `ILIR_ASSERT(a_range_zero,
        (out_valid_reg && out_reg.status == ST_RANGE) |-> (out_reg.read_value == '0),
        "out of range beat with nonzero data")
    `ILIR_ASSERT(a_adv_out, advance |=> out_valid_reg,
        "processed item lost before result register")
    `ILIR_ASSERT_ALWAYS(a_rst_idle, !aresetn |=> (!m_axis_tvalid && s_axis_tready),
        "core not idle after reset")

endmodule

`default_nettype wire

[hw/rtl/ilir_list.sv]
// ----------------------------------------------------------------------------
// ilir_list
// row of word cells with element count; one command updates all cells at once
// ----------------------------------------------------------------------------
`default_nettype none

module ilir_list #(
    parameter int MAX_ELEMENTS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  ilir_pkg::op_t  op,
    output ilir_pkg::res_t res
);
    import ilir_pkg::*;

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = $clog2(MAX_ELEMENTS);

    logic [VAL_W-1:0] cells_reg  [MAX_ELEMENTS];
    logic [VAL_W-1:0] cells_next [MAX_ELEMENTS];
    logic [CW-1:0]    count_reg, count_next;

    logic             pos_neg;
    logic [POS_W-1:0] pos_mag;
    logic             pos_ge;
    logic             full;
    logic [IW-1:0]    pos_idx;
    logic [IW-1:0]    cnt_idx;
    logic [IW-1:0]    at;
    logic             ins;
    logic             del;
    status_t          status;
    logic [VAL_W-1:0] rd;
    logic [CW+LEN_W-1:0] len_ext;

    assign pos_neg = op.position[POS_W-1];
    assign pos_mag = {1'b0, op.position[POS_W-2:0]};
    // a negative position is never at or past the length
    assign pos_ge  = !pos_neg && (pos_mag >= POS_W'(count_reg));
    assign full    = count_reg == CW'(MAX_ELEMENTS);
    assign pos_idx = op.position[IW-1:0];
    assign cnt_idx = count_reg[IW-1:0];

    always_comb begin
        status     = ST_DONE;
        rd         = '0;
        count_next = count_reg;
        ins        = 1'b0;
        del        = 1'b0;
        at         = pos_idx;
        case (op.cmd)
            CMD_APPEND, CMD_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ins        = 1'b1;
                    count_next = count_reg + CW'(1);
                    // insert past the end appends, at or below zero goes to the front
                    if (op.cmd == CMD_APPEND || pos_ge) begin
                        at = cnt_idx;
                    end else if (pos_neg) begin
                        at = '0;
                    end
                end
            end
            CMD_REMOVE, CMD_READ: begin
                if (pos_neg || pos_ge) begin
                    status = ST_RANGE;
                end else if (op.cmd == CMD_READ) begin
                    rd = cells_reg[pos_idx];
                end else begin
                    del        = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    // every cell picks its own, its lower or its upper neighbor, or the inserted value
    always_comb begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            cells_next[i] = cells_reg[i];
        end
        if (ins) begin
            for (int i = 1; i < MAX_ELEMENTS; i++) begin
                if (IW'(i) > at) begin
                    cells_next[i] = cells_reg[i-1];
                end
            end
            for (int i = 0; i < MAX_ELEMENTS; i++) begin
                if (IW'(i) == at) begin
                    cells_next[i] = op.value;
                end
            end
        end
        if (del) begin
            for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
                if (IW'(i) >= at) begin
                    cells_next[i] = cells_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (en) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < MAX_ELEMENTS; i++) begin
                cells_reg[i] <= cells_next[i];
            end
        end
    end

    assign len_ext        = {{LEN_W{1'b0}}, count_next};
    assign res.status     = status;
    assign res.read_value = rd;
    assign res.length     = len_ext[LEN_W-1:0];

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: indexed list core testbench
// drives command beats on s_axis and checks every result beat on m_axis
// against a shadow list kept in the testbench, with random gaps and stalls
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import ilir_pkg::*;

    localparam int DEPTH      = 16;
    localparam int LONG_HOLD  = 300;
    localparam int CYCLE_CAP  = 400000;
    localparam int CHUNKS     = 8;
    localparam int CHUNK_OPS  = 200;

    typedef struct {
        status_t                 status;
        logic signed [VAL_W-1:0] read_value;
        logic [LEN_W-1:0]        length;
    } list_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [1:0] cmd, [17:2] position, [49:18] value, [55:50] zero
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [1:0] status, [33:2] read_value, [38:34] length, [39] zero
    logic [39:0] m_axis_tdata;

    op_t          ops_to_send[$];
    list_result_t results_due[$];

    // shadow copy of the list contents
    logic [VAL_W-1:0] list_cells[DEPTH];
    int               list_len = 0;

    bit op_taken, result_taken;
    int errors = 0;
    int cycle_count = 0;

    int send_wait = 0, send_stretch = 0;
    bit send_calm;
    int stall_left = 0, recv_stretch = 0;
    bit recv_calm;
    int hold_requests = 0, holds_served = 0, hold_left = 0;

    indexed_list_insert_remove_core #(
        .MAX_ELEMENTS (DEPTH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic list_result_t apply_list_op(op_t op);
        list_result_t r;
        int pos;
        int at;
        r.status     = ST_DONE;
        r.read_value = '0;
        pos = $signed(op.position);
        if (op.cmd == CMD_APPEND || op.cmd == CMD_INSERT) begin
            if (list_len >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                if (op.cmd == CMD_APPEND || pos >= list_len)
                    at = list_len;
                else if (pos <= 0)
                    at = 0;
                else
                    at = pos;
                for (int i = list_len; i > at; i--)
                    list_cells[i] = list_cells[i-1];
                list_cells[at] = op.value;
                list_len++;
            end
        end else if (pos < 0 || pos >= list_len) begin
            r.status = ST_RANGE;
        end else if (op.cmd == CMD_READ) begin
            r.read_value = list_cells[pos];
        end else begin
            for (int i = pos; i + 1 < list_len; i++)
                list_cells[i] = list_cells[i+1];
            list_len--;
        end
        r.length = list_len[LEN_W-1:0];
        return r;
    endfunction

    // wait per beat, with occasional stretches of back-to-back beats
    function automatic int draw_wait(inout int stretch, inout bit calm);
        if (stretch == 0) begin
            calm    = ($urandom_range(0, 3) == 0);
            stretch = $urandom_range(10, 60);
        end
        stretch--;
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic op_t make_op(cmd_t cmd, int pos, logic [VAL_W-1:0] val);
        op_t op;
        op.cmd      = cmd;
        op.position = pos[POS_W-1:0];
        op.value    = val;
        return op;
    endfunction

    // append one command beat to the pending queue
    function automatic void queue_op(op_t op);
        ops_to_send = {ops_to_send, op};
    endfunction

    function automatic op_t random_op(bit growing);
        int   r;
        int   pos;
        cmd_t cmd;
        logic [VAL_W-1:0] val;
        r = $urandom_range(0, 9);
        if (growing)
            cmd = (r < 4) ? CMD_APPEND : (r < 7) ? CMD_INSERT : (r < 8) ? CMD_REMOVE : CMD_READ;
        else
            cmd = (r < 1) ? CMD_APPEND : (r < 2) ? CMD_INSERT : (r < 7) ? CMD_REMOVE : CMD_READ;
        if ($urandom_range(0, 4) == 0)
            pos = $urandom_range(0, 65535);
        else
            pos = $urandom_range(0, 19) - 2;
        case ($urandom_range(0, 19))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7fff_ffff;
            2:       val = '0;
            3:       val = '1;
            default: val = $urandom;
        endcase
        return make_op(cmd, pos, val);
    endfunction

    task automatic wait_drained();
        while (ops_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0)
            @(posedge aclk);
    endtask

    // sender
    always @(negedge aclk) begin : drive_ops
        op_t op;
        if (aresetn && (!s_axis_tvalid || op_taken)) begin
            if (send_wait != 0) begin
                s_axis_tvalid <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (ops_to_send.size() != 0) begin
                op = ops_to_send.pop_front();
                s_axis_tdata  <= {6'd0, op.value, op.position, op.cmd};
                s_axis_tvalid <= 1'b1;
                send_wait <= draw_wait(send_stretch, send_calm);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin : drive_ready
        int n;
        if (aresetn) begin
            if (holds_served != hold_requests) begin
                holds_served  <= hold_requests;
                hold_left     <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (result_taken) begin
                n = draw_wait(recv_stretch, recv_calm);
                stall_left    <= n;
                m_axis_tready <= (n == 0);
            end else if (stall_left != 0) begin
                stall_left    <= stall_left - 1;
                m_axis_tready <= (stall_left == 1);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watch_beats
        op_t          got_op;
        list_result_t due;
        if (!aresetn) begin
            op_taken     <= 1'b0;
            result_taken <= 1'b0;
        end else begin
            op_taken     <= s_axis_tvalid && s_axis_tready;
            result_taken <= m_axis_tvalid && m_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                got_op.cmd      = cmd_t'(s_axis_tdata[1:0]);
                got_op.position = s_axis_tdata[17:2];
                got_op.value    = s_axis_tdata[49:18];
                results_due = {results_due, apply_list_op(got_op)};
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got tdata %h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    due = results_due.pop_front();
                    if (m_axis_tdata[1:0] != due.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, due.status, m_axis_tdata[1:0]);
                        errors++;
                    end
                    if (m_axis_tdata[33:2] != due.read_value) begin
                        $display("%0t: read_value expected %h, got %h",
                                 $time, due.read_value, m_axis_tdata[33:2]);
                        errors++;
                    end
                    if (m_axis_tdata[38:34] != due.length) begin
                        $display("%0t: length expected %0d, got %0d",
                                 $time, due.length, m_axis_tdata[38:34]);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty list: remove and read are out of range
        queue_op(make_op(CMD_READ,   0, 32'h0));
        queue_op(make_op(CMD_REMOVE, 0, 32'h0));
        // negative insert on an empty list lands at the front
        queue_op(make_op(CMD_INSERT, -32768, 32'h8000_0000));
        queue_op(make_op(CMD_APPEND, 0,      32'h7fff_ffff));
        queue_op(make_op(CMD_INSERT, 0,      32'h0000_0000));
        queue_op(make_op(CMD_INSERT, 1,      32'hffff_ffff));
        // past the end and exactly at the length both append
        queue_op(make_op(CMD_INSERT, 32767,  32'h1234_5678));
        queue_op(make_op(CMD_INSERT, 5,      32'ha5a5_5a5a));
        for (int i = 0; i < 10; i++)
            queue_op(make_op(CMD_APPEND, 0, $urandom));
        // full list refuses both
        queue_op(make_op(CMD_APPEND, 0,  32'hdead_beef));
        queue_op(make_op(CMD_INSERT, -1, 32'h0bad_f00d));
        queue_op(make_op(CMD_READ,   -1, 32'h0));
        queue_op(make_op(CMD_READ,   16, 32'h0));
        queue_op(make_op(CMD_READ,   15, 32'h0));
        queue_op(make_op(CMD_REMOVE, 32767,  32'h0));
        queue_op(make_op(CMD_REMOVE, -32768, 32'h0));
        queue_op(make_op(CMD_REMOVE, 7,  32'h0));
        queue_op(make_op(CMD_REMOVE, 0,  32'h0));
        queue_op(make_op(CMD_REMOVE, 13, 32'h0));
        wait_drained();

        for (int c = 0; c < CHUNKS; c++) begin
            if (c == 4)
                wait_drained();
            // alternate between filling and draining runs so both ends are hit
            for (int k = 0; k < CHUNK_OPS; k++)
                queue_op(random_op(((k / 40) % 2) == 0));
            if (c == 1 || c == 6)
                hold_requests++;
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (errors == 0 && results_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
